// ===== rtl/core/rbag_pkg.sv =====
// Package with the constants and types of the rectangle blit address generator.
package rbag_pkg;

   // Fixed field widths of the request, response and register port.
   localparam int PIXEL_W   = 8;
   localparam int WADDR_W   = 24;
   localparam int PITCH_W   = 13;
   localparam int POS_W     = 12;
   localparam int SIZE_W    = 13;
   localparam int MODE_W    = 2;
   localparam int BASE_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   // Default values of the top-level parameters.
   localparam int ADDR_BITS_DEF  = 24;
   localparam int COORD_BITS_DEF = 12;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_PITCH   = 3'd0,
      CSR_DEST_X      = 3'd1,
      CSR_DEST_Y      = 3'd2,
      CSR_RECT_WIDTH  = 3'd3,
      CSR_RECT_HEIGHT = 3'd4,
      CSR_BLIT_MODE   = 3'd5,
      CSR_FILL_COLOR  = 3'd6,
      CSR_BUFFER_BASE = 3'd7
   } csr_index_type;

   // Blit mode codes; the unused code behaves as plain copy.
   localparam logic [MODE_W-1:0] MODE_COPY   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_KEYED  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FILL   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Reset values of the registers.
   localparam logic [PITCH_W-1:0] PITCH_RST = 13'd1024;
   localparam logic [SIZE_W-1:0]  SIZE_RST  = 13'd1;

   // Transparent key value in keyed copy mode.
   localparam logic [PIXEL_W-1:0] KEY_PIXEL = 8'd0;

endpackage

// ===== rtl/core/rect_blit_address_generator.sv =====
// Top level of the rectangle blit address generator.
//
// Usage: program the registers through the csr_ port (csr_we, csr_index,
// csr_wdata) while no request is in flight. Each request on the req_ channel
// carries one source pixel, in row-major order over the destination
// rectangle (its value is ignored in solid fill mode). Each request yields
// exactly one response on the rsp_ channel: the frame-buffer byte address,
// the data, a write enable, an address overflow flag and a last pixel flag.
// After the last pixel the column and row counters restart at the corner.
//
// Pipeline: an accepted request is held in the input register and then in
// the response register, which drives rsp_valid. One input register holds
// the pixel and counter values, and the logic behind it computes the
// address with a single multiply and add into the response register.
// Throughput is one request per cycle while rsp_ready is high; while a
// response waits the input stage accepts only if it is empty, so a stalled
// receiver holds the response register and then backs up into the input
// stage before req_ready drops.
//
// Synchronous reset clears both stages, the counters and restores the
// register reset values.
module rect_blit_address_generator #(
   parameter int ADDR_BITS  = rbag_pkg::ADDR_BITS_DEF,
   parameter int COORD_BITS = rbag_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write port
   input  logic                            csr_we,
   input  logic [rbag_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rbag_pkg::CSR_DAT_W-1:0]  csr_wdata,
   // Request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rbag_pkg::PIXEL_W-1:0]    req_src_pixel,
   // Response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rbag_pkg::WADDR_W-1:0]    rsp_write_address,
   output logic [rbag_pkg::PIXEL_W-1:0]    rsp_write_data,
   output logic                            rsp_write_enable,
   output logic                            rsp_address_overflow,
   output logic                            rsp_last_pixel
);
   import rbag_pkg::*;

   // Derived widths.
   localparam int CMP_W    = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
   localparam int ROWSUM_W = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 1;
   localparam int PROD_W   = ROWSUM_W + PITCH_W;
   localparam int WIDE_W   = (ADDR_BITS > WADDR_W) ? ADDR_BITS : WADDR_W;
   localparam int SUM_W    = ((PROD_W > WIDE_W) ? PROD_W : WIDE_W) + 2;
   localparam logic [CMP_W-1:0]  SIZE_LIM  = CMP_W'(1) << COORD_BITS;
   localparam logic [63:0]       AMASK64   = (64'd1 << ADDR_BITS) - 64'd1;
   localparam logic [WADDR_W-1:0] ADDR_MASK = AMASK64[WADDR_W-1:0];

   // Configuration registers.
   logic [PITCH_W-1:0] row_pitch_ff;
   logic [POS_W-1:0]   dest_x_ff;
   logic [POS_W-1:0]   dest_y_ff;
   logic [SIZE_W-1:0]  rect_width_ff;
   logic [SIZE_W-1:0]  rect_height_ff;
   logic [MODE_W-1:0]  blit_mode_ff;
   logic [PIXEL_W-1:0] fill_color_ff;
   logic [BASE_W-1:0]  buffer_base_ff;

   // Counters and pipeline registers.
   logic [COORD_BITS-1:0] col_ff, col_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic                  s1_vld_ff, s1_vld_in;
   logic [PIXEL_W-1:0]    s1_pix_ff;
   logic [COORD_BITS-1:0] s1_col_ff;
   logic [COORD_BITS-1:0] s1_row_ff;
   logic                  s1_last_ff;
   logic                  out_vld_ff, out_vld_in;
   logic [WADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic [PIXEL_W-1:0]    out_data_ff, out_data_in;
   logic                  out_en_ff, out_en_in;
   logic                  out_ovf_ff, out_ovf_in;
   logic                  out_last_ff;

   logic                  req_fire;
   logic                  advance;
   logic [CMP_W-1:0]      w_ext, h_ext;
   logic [COORD_BITS-1:0] w_last, h_last;
   logic                  last_col, last_row;
   logic [ROWSUM_W-1:0]   row_sum;
   logic [PROD_W-1:0]     row_prod;
   logic [SUM_W-1:0]      addr_sum;
   logic [PIXEL_W-1:0]    raw_data;
   logic                  raw_en;

   // Register writes from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_pitch_ff   <= PITCH_RST;
         dest_x_ff      <= '0;
         dest_y_ff      <= '0;
         rect_width_ff  <= SIZE_RST;
         rect_height_ff <= SIZE_RST;
         blit_mode_ff   <= MODE_COPY;
         fill_color_ff  <= '0;
         buffer_base_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_PITCH:   row_pitch_ff   <= csr_wdata[PITCH_W-1:0];
            CSR_DEST_X:      dest_x_ff      <= csr_wdata[POS_W-1:0];
            CSR_DEST_Y:      dest_y_ff      <= csr_wdata[POS_W-1:0];
            CSR_RECT_WIDTH:  rect_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_RECT_HEIGHT: rect_height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_BLIT_MODE:   blit_mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_FILL_COLOR:  fill_color_ff  <= csr_wdata[PIXEL_W-1:0];
            CSR_BUFFER_BASE: buffer_base_ff <= csr_wdata[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: the response register advances when empty or taken.
   assign advance   = !out_vld_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // Last column and row indexes; zero size acts as one, oversize clamps.
   always_comb begin
      w_ext = CMP_W'(rect_width_ff);
      h_ext = CMP_W'(rect_height_ff);
      if (w_ext == '0) begin
         w_last = '0;
      end else if (w_ext > SIZE_LIM) begin
         w_last = '1;
      end else begin
         w_last = COORD_BITS'(w_ext - CMP_W'(1));
      end
      if (h_ext == '0) begin
         h_last = '0;
      end else if (h_ext > SIZE_LIM) begin
         h_last = '1;
      end else begin
         h_last = COORD_BITS'(h_ext - CMP_W'(1));
      end
      last_col = col_ff >= w_last;
      last_row = row_ff >= h_last;
   end

   // Counter stepping in row-major order.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + COORD_BITS'(1);
         end else begin
            col_in = col_ff + COORD_BITS'(1);
         end
      end
   end

   // Input stage valid.
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_fire) begin
         s1_vld_in = 1'b1;
      end else if (advance) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   // Input stage payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff  <= req_src_pixel;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_last_ff <= last_col && last_row;
      end
   end

   // Address: base + (dest y + row) * pitch + dest x + column.
   always_comb begin
      row_sum  = ROWSUM_W'(dest_y_ff) + ROWSUM_W'(s1_row_ff);
      row_prod = PROD_W'(row_sum) * PROD_W'(row_pitch_ff);
      addr_sum = SUM_W'(buffer_base_ff) + SUM_W'(row_prod)
               + SUM_W'(dest_x_ff) + SUM_W'(s1_col_ff);
      out_ovf_in  = |addr_sum[SUM_W-1:ADDR_BITS];
      out_addr_in = addr_sum[WADDR_W-1:0] & ADDR_MASK;
   end

   // Data and enable by mode; a transparent pixel writes nothing.
   always_comb begin
      case (blit_mode_ff)
         MODE_FILL: begin
            raw_data = fill_color_ff;
            raw_en   = 1'b1;
         end
         MODE_KEYED: begin
            raw_data = s1_pix_ff;
            raw_en   = s1_pix_ff != KEY_PIXEL;
         end
         default: begin
            raw_data = s1_pix_ff;
            raw_en   = 1'b1;
         end
      endcase
      out_en_in   = raw_en && !out_ovf_in;
      out_data_in = (raw_en || out_ovf_in) ? raw_data : '0;
   end

   // Response stage valid.
   always_comb begin
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   // Response stage payload.
   always_ff @(posedge clock) begin
      if (advance && s1_vld_ff) begin
         out_addr_ff <= out_addr_in;
         out_data_ff <= out_data_in;
         out_en_ff   <= out_en_in;
         out_ovf_ff  <= out_ovf_in;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_write_address    = out_addr_ff;
   assign rsp_write_data       = out_data_ff;
   assign rsp_write_enable     = out_en_ff;
   assign rsp_address_overflow = out_ovf_ff;
   assign rsp_last_pixel       = out_last_ff;

endmodule
